// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, all disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: property violated");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`endif

// File: hw/rtl/bole_pkg.sv
// ---------------------------------------------------------------------------
// bole_pkg
// Operation and status codes, field widths and word types for the list engine.
// ---------------------------------------------------------------------------
package bole_pkg;

    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 4;
    localparam int STAT_W  = 3;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_IDX  = 3'd2,
        OP_RM_HEAD  = 3'd3,
        OP_RM_TAIL  = 3'd4,
        OP_RM_VAL   = 3'd5,
        OP_RM_IDX   = 3'd6,
        OP_SEARCH   = 3'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 3'd0,
        ST_FULL  = 3'd1,
        ST_RANGE = 3'd2,
        ST_EMPTY = 3'd3,
        ST_MISS  = 3'd4
    } t_status;

    // one command word
    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        index;
    } t_cmd;

    // one result word
    typedef struct packed {
        t_status              status;
        logic                 found;
        logic [POS_W-1:0]     position;
        logic [COUNT_W-1:0]   count;
    } t_result;

endpackage

// File: hw/rtl/bounded_ordered_list_engine_core.sv
// ---------------------------------------------------------------------------
// bounded_ordered_list_engine_core
// Bounded ordered list of signed 32-bit values with insert, remove and search.
// ---------------------------------------------------------------------------
//
//  channel  | handshake                 | word
//  ---------+---------------------------+-------------------------------------
//  command  | i_in_valid / o_in_ready   | i_op, i_value, i_index
//  result   | o_out_valid / i_out_ready | o_status, o_found, o_position, o_count
//
//  Entries sit in order in one RAM and are shifted or scanned one at a time.
//  A full, range or empty outcome and a tail removal touch no entry; an
//  insert or remove shifts the entries past its position, a search scans
//  from the head until a hit or the end, and a remove by value scans for
//  its value first and on a hit shifts as a remove does.
//  Reset clears count and control only (synchronous, active low). A held
//  result never blocks a command; a finished one waits while the slot is full.
// ---------------------------------------------------------------------------
module bounded_ordered_list_engine_core import bole_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // command channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OP_W-1:0]         i_op,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [IDX_W-1:0]        i_index,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [STAT_W-1:0]       o_status,
    output logic                    o_found,
    output logic [POS_W-1:0]        o_position,
    output logic [COUNT_W-1:0]      o_count
);

    t_cmd    w_cmd;
    t_result w_res;
    logic    w_start;
    logic    w_idle;
    logic    w_done;
    logic    w_res_ready;

    logic    r_out_valid;
    t_result r_out;

    // command word goes straight to the sequencer, which latches it on start
    assign w_cmd.op    = t_op'(i_op);
    assign w_cmd.value = i_value;
    assign w_cmd.index = i_index;

    assign o_in_ready  = w_idle;
    assign w_start     = i_in_valid && w_idle;

    // result slot is free when empty or draining this cycle
    assign w_res_ready = !r_out_valid || i_out_ready;

    bole_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_cmd       (w_cmd),
        .i_res_ready (w_res_ready),
        .o_idle      (w_idle),
        .o_done      (w_done),
        .o_res       (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_found     = r_out.found;
    assign o_position  = r_out.position;
    assign o_count     = r_out.count;

endmodule

// File: hw/rtl/bole_ram.sv
// ---------------------------------------------------------------------------
// bole_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bole_seq.sv
// ---------------------------------------------------------------------------
// bole_seq
// Entry RAM and the sequencer that shifts, scans and counts over it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bole_seq import bole_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    input  logic    i_res_ready,
    output logic    o_idle,
    output logic    o_done,
    output t_result o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_REM  = 5'b00100,
        S_SCAN = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_sidx, n_sidx;
    t_op               r_op, n_op;
    logic [VAL_W-1:0]  r_value, n_value;
    t_status           r_status, n_status;
    logic              r_found, n_found;
    logic [POS_W-1:0]  r_position, n_position;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [VAL_W-1:0]  w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [VAL_W-1:0]  w_rdata;

    logic              w_full, w_empty, w_idx_lt;
    logic [CW:0]       w_ptr_inc1, w_ptr_inc2, w_cnt_x;
    logic [CW-1:0]     w_ptr_dec1, w_ptr_dec2;
    logic              w_hit;

    bole_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_full     = (r_cnt == CW'(DEPTH));
    assign w_empty    = (r_cnt == '0);
    assign w_idx_lt   = (XW'(i_cmd.index) < XW'(r_cnt));
    assign w_cnt_x    = {1'b0, r_cnt};
    assign w_ptr_inc1 = {1'b0, r_ptr} + (CW+1)'(1);
    assign w_ptr_inc2 = {1'b0, r_ptr} + (CW+1)'(2);
    assign w_ptr_dec1 = r_ptr - CW'(1);
    assign w_ptr_dec2 = r_ptr - CW'(2);
    assign w_hit      = r_pend && (w_rdata == r_value);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pend     = r_pend;
        n_ptr      = r_ptr;
        n_pos      = r_pos;
        n_sidx     = r_sidx;
        n_op       = r_op;
        n_value    = r_value;
        n_status   = r_status;
        n_found    = r_found;
        n_position = r_position;
        w_we       = 1'b0;
        w_waddr    = r_ptr[AW-1:0];
        w_wdata    = w_rdata;
        w_raddr    = '0;
        o_done     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op       = i_cmd.op;
                    n_value    = i_cmd.value;
                    n_status   = ST_DONE;
                    n_found    = 1'b0;
                    n_position = '0;
                    n_pend     = 1'b0;
                    n_ptr      = r_cnt;
                    case (i_cmd.op)
                        OP_INS_HEAD, OP_INS_TAIL, OP_INS_IDX: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else if (i_cmd.op == OP_INS_IDX &&
                                         i_cmd.index != '0 && !w_idx_lt) begin
                                n_status = ST_RANGE;
                                n_state  = S_RESP;
                            end else begin
                                if (i_cmd.op == OP_INS_HEAD) begin
                                    n_pos = '0;
                                end else if (i_cmd.op == OP_INS_TAIL) begin
                                    n_pos = r_cnt;
                                end else begin
                                    n_pos = CW'(i_cmd.index);
                                end
                                n_state = S_INS;
                            end
                        end
                        OP_RM_HEAD: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_REM;
                            end
                        end
                        OP_RM_TAIL: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cnt = r_cnt - CW'(1);
                            end
                            n_state = S_RESP;
                        end
                        OP_RM_VAL: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_RM_IDX: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else if (w_idx_lt) begin
                                n_ptr   = CW'(i_cmd.index);
                                n_state = S_REM;
                            end else begin
                                n_status = ST_RANGE;
                                n_state  = S_RESP;
                            end
                        end
                        OP_SEARCH: begin
                            n_ptr   = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            // shift entries up from the tail, then drop the value into the gap
            S_INS: begin
                if (!r_pend) begin
                    if (r_ptr == r_pos) begin
                        w_we    = 1'b1;
                        w_waddr = r_ptr[AW-1:0];
                        w_wdata = r_value;
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_RESP;
                    end else begin
                        w_raddr = w_ptr_dec1[AW-1:0];
                        n_pend  = 1'b1;
                    end
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_ptr[AW-1:0];
                    w_wdata = w_rdata;
                    n_ptr   = w_ptr_dec1;
                    w_raddr = w_ptr_dec2[AW-1:0];
                    n_pend  = (w_ptr_dec1 != r_pos);
                end
            end

            // close the gap at r_ptr by shifting the upper entries down
            S_REM: begin
                if (!r_pend) begin
                    if (w_ptr_inc1 >= w_cnt_x) begin
                        n_cnt   = r_cnt - CW'(1);
                        n_state = S_RESP;
                    end else begin
                        w_raddr = w_ptr_inc1[AW-1:0];
                        n_pend  = 1'b1;
                    end
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_ptr[AW-1:0];
                    w_wdata = w_rdata;
                    n_ptr   = w_ptr_inc1[CW-1:0];
                    w_raddr = w_ptr_inc2[AW-1:0];
                    n_pend  = (w_ptr_inc2 < w_cnt_x);
                end
            end

            // walk from the head; r_sidx tags the word on the read port
            S_SCAN: begin
                if (w_hit) begin
                    if (r_op == OP_SEARCH) begin
                        n_found    = 1'b1;
                        n_position = POS_W'(r_sidx);
                        n_state    = S_RESP;
                    end else begin
                        n_ptr   = r_sidx;
                        n_pend  = 1'b0;
                        n_state = S_REM;
                    end
                end else if (r_ptr < r_cnt) begin
                    w_raddr = r_ptr[AW-1:0];
                    n_sidx  = r_ptr;
                    n_ptr   = w_ptr_inc1[CW-1:0];
                    n_pend  = 1'b1;
                end else begin
                    n_status = ST_MISS;
                    n_state  = S_RESP;
                end
            end

            S_RESP: begin
                if (i_res_ready) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_pos      <= n_pos;
        r_sidx     <= n_sidx;
        r_op       <= n_op;
        r_value    <= n_value;
        r_status   <= n_status;
        r_found    <= n_found;
        r_position <= n_position;
    end

    assign o_idle = (r_state == S_IDLE);

    assign o_res.status   = r_status;
    assign o_res.found    = r_found;
    assign o_res.position = r_position;
    assign o_res.count    = COUNT_W'(r_cnt);

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(DEPTH))
    `ASSERT_IMPLY(a_we_in_shift, i_clk, i_rst_n, w_we, (r_state == S_INS) || (r_state == S_REM))
    `ASSERT_IMPLY(a_start_idle, i_clk, i_rst_n, i_start, r_state == S_IDLE)
    `ASSERT_NEXT(a_done_settles, i_clk, i_rst_n, o_done, (r_state == S_IDLE) && $stable(r_cnt))
    `ASSERT_IMPLY(a_full_cnt, i_clk, i_rst_n, o_done && (r_status == ST_FULL), w_full)

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for the bounded ordered list engine. A queue model of the list
// predicts each result word. Directed words cover the empty, full and edge
// cases, then random traffic runs under three idle patterns.
// ---------------------------------------------------------------------------
module tb import bole_pkg::*; ();

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 60;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_op        = '0;
    logic signed [VAL_W-1:0] i_value     = '0;
    logic [IDX_W-1:0]        i_index     = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [STAT_W-1:0]       o_status;
    logic                    o_found;
    logic [POS_W-1:0]        o_position;
    logic [COUNT_W-1:0]      o_count;

    // model of the list contents, head at index 0
    logic [VAL_W-1:0] list_q[$];
    // result words still owed by the engine, oldest first
    t_result          owed_q[$];

    int fail_count   = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int stall_cycles = 0;

    bounded_ordered_list_engine_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_value     (i_value),
        .i_index     (i_index),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_position  (o_position),
        .o_count     (o_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one operation to the list model and return the word it should give.
    function automatic t_result apply_list_op(t_op op, logic [VAL_W-1:0] value,
                                              logic [IDX_W-1:0] index);
        t_result res;
        int      hit;
        bit      full;
        bit      empty;
        res.status   = ST_DONE;
        res.found    = 1'b0;
        res.position = '0;
        hit          = -1;
        full         = list_q.size() >= DEPTH;
        empty        = list_q.size() == 0;
        foreach (list_q[i]) begin
            if (hit < 0 && list_q[i] == value) hit = i;
        end
        case (op)
            OP_INS_HEAD: begin
                if (full) res.status = ST_FULL;
                else list_q.push_front(value);
            end
            OP_INS_TAIL: begin
                if (full) res.status = ST_FULL;
                else list_q.push_back(value);
            end
            OP_INS_IDX: begin
                // fullness wins over a bad index
                if (full) res.status = ST_FULL;
                else if (index == 0 || int'(index) < list_q.size()) list_q.insert(index, value);
                else res.status = ST_RANGE;
            end
            OP_RM_HEAD: begin
                if (empty) res.status = ST_EMPTY;
                else void'(list_q.pop_front());
            end
            OP_RM_TAIL: begin
                if (empty) res.status = ST_EMPTY;
                else void'(list_q.pop_back());
            end
            OP_RM_VAL: begin
                if (empty) res.status = ST_EMPTY;
                else if (hit >= 0) list_q.delete(hit);
                else res.status = ST_MISS;
            end
            OP_RM_IDX: begin
                if (empty) res.status = ST_EMPTY;
                else if (int'(index) < list_q.size()) list_q.delete(index);
                else res.status = ST_RANGE;
            end
            OP_SEARCH: begin
                if (hit >= 0) begin
                    res.found    = 1'b1;
                    res.position = hit[POS_W-1:0];
                end else begin
                    res.status = ST_MISS;
                end
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(list_q.size());
        return res;
    endfunction

    // Present one command word, hold it until taken, then log what it should give.
    task automatic send_cmd(t_op op, logic [VAL_W-1:0] value, logic [IDX_W-1:0] index);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        i_index    <= index;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        owed_q.push_back(apply_list_op(op, value, index));
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= $urandom_range(99) >= rx_idle_pct;
    end

    // Result checker: every accepted word against the oldest owed one
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_q.size() == 0) begin
                $error("result word with nothing owed: status %0d count %0d",
                       o_status, o_count);
                fail_count++;
            end else begin
                exp_res = owed_q.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    fail_count++;
                end
                if (o_found !== exp_res.found) begin
                    $error("found: expected %0d, got %0d", exp_res.found, o_found);
                    fail_count++;
                end
                if (o_position !== exp_res.position) begin
                    $error("position: expected %0d, got %0d", exp_res.position, o_position);
                    fail_count++;
                end
                if (o_count !== exp_res.count) begin
                    $error("count: expected %0d, got %0d", exp_res.count, o_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Every removal and lookup on an empty list, plus the index edge on insert.
    task automatic test_empty_list();
        send_cmd(OP_RM_HEAD, 32'd1, 4'd0);
        send_cmd(OP_RM_TAIL, 32'd1, 4'd0);
        send_cmd(OP_RM_VAL,  32'd0, 4'd0);
        send_cmd(OP_RM_IDX,  32'd0, 4'd0);
        send_cmd(OP_SEARCH,  32'd0, 4'd0);
        send_cmd(OP_INS_IDX, 32'd5, 4'd3);
        send_cmd(OP_INS_IDX, 32'h8000_0000, 4'd0);
    endtask

    // Fill to the bound, hit the full flag on each insert form, probe the tail slot.
    task automatic test_fill_to_full();
        send_cmd(OP_INS_HEAD, 32'h7FFF_FFFF, 4'd0);
        send_cmd(OP_INS_TAIL, 32'hFFFF_FFFF, 4'd15);
        while (list_q.size() < DEPTH - 1)
            send_cmd(OP_INS_TAIL, $urandom, 4'($urandom));
        send_cmd(OP_INS_TAIL, 32'h5A5A_A5A5, 4'd0);
        send_cmd(OP_INS_HEAD, 32'd9, 4'd0);
        send_cmd(OP_INS_TAIL, 32'd9, 4'd0);
        send_cmd(OP_INS_IDX,  32'd9, 4'd15);
        send_cmd(OP_SEARCH,   32'h5A5A_A5A5, 4'd0);
        send_cmd(OP_RM_IDX,   32'd0, 4'd15);
    endtask

    // Random traffic that drifts between growing and shrinking phases, so the
    // list keeps running into both the full and the empty edges.
    task automatic random_traffic(int n_words);
        bit               growing;
        int               roll;
        t_op              op;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
        growing = 1'b1;
        repeat (n_words) begin
            if ($urandom_range(29) == 0) growing = !growing;
            roll = $urandom_range(99);
            if (roll < (growing ? 60 : 25)) op = t_op'($urandom_range(2));
            else if (roll < 85) op = t_op'($urandom_range(6, 3));
            else op = OP_SEARCH;
            // mostly values already held or from a tiny pool, so matches and
            // duplicates are common
            roll = $urandom_range(99);
            if (roll < 45 && list_q.size() != 0)
                value = list_q[$urandom_range(list_q.size() - 1)];
            else if (roll < 70)
                value = $urandom_range(7) - 3;
            else
                value = $urandom;
            if ($urandom_range(99) < 70)
                index = IDX_W'($urandom_range(list_q.size() > 15 ? 15 : list_q.size()));
            else
                index = IDX_W'($urandom_range(15));
            send_cmd(op, value, index);
        end
    endtask

    task automatic test_slow_receiver();
        tx_idle_pct = 22;
        rx_idle_pct = 76;
        random_traffic(283);
    endtask

    task automatic test_slow_sender();
        tx_idle_pct = 76;
        rx_idle_pct = 22;
        random_traffic(283);
    endtask

    task automatic test_full_rate();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_traffic(284);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_fill_to_full();
        test_slow_receiver();
        test_slow_sender();
        test_full_rate();
        i_in_valid <= 1'b0;
        while (owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
